// ----- hw/rtl/psp_pkg.sv -----
`default_nettype none

package psp_pkg;

   localparam int PACKET_BYTES = 188;
   localparam int POS_W        = $clog2(PACKET_BYTES + 1);
   localparam int PID_W        = 13;
   localparam int CRC_W        = 32;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TAIL_BYTES   = 4;
   localparam int SEL_W        = $clog2(TAIL_BYTES + 1);
   localparam int HEADER_BYTES = 4;
   localparam int MAX_RUN      = PACKET_BYTES - HEADER_BYTES;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [CRC_W-1:0] CRC_INIT = '1;

   localparam logic [7:0] SYNC_BYTE    = 8'h47;
   localparam logic [7:0] CC_BASE      = 8'h10;
   localparam logic [7:0] POINTER_BYTE = 8'h00;
   localparam logic [7:0] PAD_BYTE     = 8'hFF;

   typedef struct packed {
      logic [7:0]       data;
      logic             last;
      logic [CRC_W-1:0] crc;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type head;
   } queue_out_type;

endpackage

`default_nettype wire

// ----- hw/rtl/psp_front.sv -----
`default_nettype none

module psp_front (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_push,
   input  wire                logic [7:0] req_section_byte,
   input  wire                logic req_final_byte,
   input  wire                logic queue_full,
   output psp_pkg::entry_type       push_entry,
   output logic                     push_valid
);
   import psp_pkg::*;

   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic [CRC_W-1:0] crc_next;
   logic             accept;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
      logic [CRC_W-1:0] c;
      logic             top;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         top = c[CRC_W-1] ^ b[i];
         c   = {c[CRC_W-2:0], 1'b0};
         if (top) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   assign accept   = req_push && !queue_full;
   assign crc_next = crc_byte(crc_ff, req_section_byte);

   always_comb begin
      crc_in = crc_ff;
      if (accept) begin
         crc_in = req_final_byte ? CRC_INIT : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign push_valid      = accept;
   assign push_entry.data = req_section_byte;
   assign push_entry.last = req_final_byte;
   assign push_entry.crc  = crc_next;

endmodule

`default_nettype wire

// ----- hw/rtl/psp_queue.sv -----
`default_nettype none

module psp_queue (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic push_valid,
   input  wire psp_pkg::entry_type  push_entry,
   output logic                     full,
   output psp_pkg::queue_out_type   q_out,
   input  wire                logic pop
);
   import psp_pkg::*;

   entry_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_pop;

   assign full        = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_out.valid = (count_ff != '0);
   assign q_out.head  = entries_ff[rd_ptr_ff];
   assign do_pop      = pop && q_out.valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/psp_back.sv -----
`default_nettype none

module psp_back (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic [psp_pkg::PID_W-1:0] stream_pid,
   input  wire psp_pkg::queue_out_type q_out,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire                logic rsp_pop,
   output logic               [7:0] rsp_out_byte,
   output logic               [7:0] rsp_run_length,
   output logic                     rsp_section_done
);
   import psp_pkg::*;

   typedef enum logic [5:0] {
      ST_DATA   = 6'b000001,
      ST_PID_HI = 6'b000010,
      ST_PID_LO = 6'b000100,
      ST_CC     = 6'b001000,
      ST_PTR    = 6'b010000,
      ST_PAD    = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SEL_W-1:0]   sel_ff, sel_in;
   logic [3:0]         cc_ff, cc_in;
   logic               first_ff, first_in;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic [7:0]         run_ff, run_in;
   logic               done_ff, done_in;

   logic               advance;
   logic               pop_cmd;
   logic [POS_W:0]     pos_inc;
   logic [POS_W-1:0]   pos_wrap;
   logic [7:0]         cur_byte;
   logic [3:0]         cc_next;
   entry_type          head;

   assign head     = q_out.head;
   assign advance  = q_out.valid && (!valid_ff || rsp_pop);
   assign pos_inc  = {1'b0, pos_ff} + (POS_W + 1)'(1);
   assign pos_wrap = (pos_inc == (POS_W + 1)'(PACKET_BYTES)) ? '0 : pos_inc[POS_W-1:0];
   assign cc_next  = cc_ff + 4'd1;

   always_comb begin
      case (sel_ff)
         SEL_W'(1): cur_byte = head.crc[31:24];
         SEL_W'(2): cur_byte = head.crc[23:16];
         SEL_W'(3): cur_byte = head.crc[15:8];
         SEL_W'(4): cur_byte = head.crc[7:0];
         default:   cur_byte = head.data;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      sel_in   = sel_ff;
      cc_in    = cc_ff;
      first_in = first_ff;
      byte_in  = cur_byte;
      run_in   = 8'd1;
      done_in  = 1'b0;
      pop_cmd  = 1'b0;
      unique case (state_ff)
         ST_DATA: begin
            if (pos_ff == '0) begin
               byte_in  = SYNC_BYTE;
               state_in = ST_PID_HI;
            end else begin
               pos_in  = pos_wrap;
               done_in = head.last && (sel_ff == SEL_W'(TAIL_BYTES)) && (pos_wrap == '0);
               if (head.last && (sel_ff != SEL_W'(TAIL_BYTES))) begin
                  sel_in = sel_ff + SEL_W'(1);
               end else if (head.last && (pos_wrap != '0)) begin
                  state_in = ST_PAD;
               end else begin
                  pop_cmd = 1'b1;
                  sel_in  = '0;
                  if (head.last) begin
                     first_in = 1'b1;
                  end
               end
            end
         end
         ST_PID_HI: begin
            byte_in  = {1'b0, first_ff, 1'b0, stream_pid[PID_W-1:8]};
            state_in = ST_PID_LO;
         end
         ST_PID_LO: begin
            byte_in  = stream_pid[7:0];
            state_in = ST_CC;
         end
         ST_CC: begin
            byte_in  = CC_BASE | {4'b0000, cc_next};
            cc_in    = cc_next;
            pos_in   = POS_W'(HEADER_BYTES);
            state_in = first_ff ? ST_PTR : ST_DATA;
         end
         ST_PTR: begin
            byte_in  = POINTER_BYTE;
            pos_in   = POS_W'(HEADER_BYTES + 1);
            first_in = 1'b0;
            state_in = ST_DATA;
         end
         ST_PAD: begin
            byte_in  = PAD_BYTE;
            run_in   = 8'(PACKET_BYTES - int'(pos_ff));
            done_in  = 1'b1;
            pos_in   = '0;
            first_in = 1'b1;
            sel_in   = '0;
            pop_cmd  = 1'b1;
            state_in = ST_DATA;
         end
         default: begin
            state_in = ST_DATA;
         end
      endcase
   end

   assign q_pop    = advance && pop_cmd;
   assign valid_in = advance || (valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DATA;
         pos_ff   <= '0;
         sel_ff   <= '0;
         cc_ff    <= 4'hF;
         first_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            state_ff <= state_in;
            pos_ff   <= pos_in;
            sel_ff   <= sel_in;
            cc_ff    <= cc_in;
            first_ff <= first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_run_length   = run_ff;
   assign rsp_section_done = done_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/psi_section_packetizer.sv -----
// PSI section packetizer with MPEG-2 CRC-32.
// Request channel: push one section byte with req_section_byte; set
// req_final_byte on the last byte of the section. A request is taken at an
// edge with req_push high and req_full low.
// Result channel: while rsp_empty is low the oldest result is on rsp_*;
// rsp_pop at such an edge takes it. Each result is one transport byte, or a
// run of 0xFF padding (rsp_run_length bytes) closing the last packet;
// rsp_section_done marks the section's final result.
// csr_wr_en/csr_wr_data write the 13-bit PID; write only while idle.
// A four-entry request queue decouples input from the sequencer; a taken
// request passes through it and the output register before its first result
// shows. Throughput: one result per cycle from the output sequencer while
// the queue holds an entry and the receiver pops; a body byte gives one
// result, a header four or five, the last byte four CRC results and any pad.
// Reset: PID 0, continuity 15 so the first header carries 0, queues empty.
// When the receiver stalls, the result holds, the queue fills, and req_full
// rises after four more requests.
`default_nettype none

module psi_section_packetizer (
   input  wire  logic                        clock,
   input  wire  logic                        reset,
   input  wire  logic                        req_push,
   output logic                              req_full,
   input  wire  logic [7:0]                  req_section_byte,
   input  wire  logic                        req_final_byte,
   output logic                              rsp_empty,
   input  wire  logic                        rsp_pop,
   output logic [7:0]                        rsp_out_byte,
   output logic [7:0]                        rsp_run_length,
   output logic                              rsp_section_done,
   input  wire  logic                        csr_wr_en,
   input  wire  logic [psp_pkg::PID_W-1:0]   csr_wr_data
);
   import psp_pkg::*;

   logic [PID_W-1:0] pid_ff;
   entry_type        push_entry;
   logic             push_valid;
   queue_out_type    q_out;
   logic             q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff <= '0;
      end else if (csr_wr_en) begin
         pid_ff <= csr_wr_data;
      end
   end

   psp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_section_byte (req_section_byte),
      .req_final_byte   (req_final_byte),
      .queue_full       (req_full),
      .push_entry       (push_entry),
      .push_valid       (push_valid)
   );

   psp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (req_full),
      .q_out      (q_out),
      .pop        (q_pop)
   );

   psp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .stream_pid       (pid_ff),
      .q_out            (q_out),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_length   (rsp_run_length),
      .rsp_section_done (rsp_section_done)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/psp_checker.sv -----
`default_nettype none

module psp_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_full,
   input  wire logic       rsp_empty,
   input  wire logic       rsp_pop,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic [7:0] rsp_run_length,
   input  wire logic       rsp_section_done
);
   import psp_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !req_full && rsp_empty)
      else $error("queues not empty after reset");

   a_run_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_run_length != 8'd0 && rsp_run_length <= 8'(MAX_RUN))
      else $error("run length out of range");

   a_run_is_pad: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_run_length != 8'd1 |->
         rsp_out_byte == PAD_BYTE && rsp_section_done)
      else $error("run above one that is not closing padding");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=>
         !rsp_empty && $stable(rsp_out_byte) && $stable(rsp_run_length)
         && $stable(rsp_section_done))
      else $error("stalled result changed");

endmodule

bind psi_section_packetizer psp_checker u_psp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_run_length   (rsp_run_length),
   .rsp_section_done (rsp_section_done)
);

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

module testbench;
   import psp_pkg::*;

   localparam logic [7:0] START_FLAG    = 8'h40;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         QUIET_LIMIT   = 2000;
   localparam int         MAX_SHOWN     = 10;

   typedef struct packed {
      logic [7:0] value;
      logic [7:0] run_len;
      logic       done;
   } ts_word_type;

   class section_scoreboard;
      logic [PID_W-1:0] pid;
      logic [3:0]       cc;
      logic [CRC_W-1:0] crc;
      int unsigned      pos;
      bit               open_first;
      ts_word_type      due[$];
      int unsigned      errors, requests, results, sections, packets;

      function new();
         pid        = '0;
         cc         = 4'hF;
         crc        = CRC_INIT;
         pos        = 0;
         open_first = 1'b1;
         errors     = 0;
         requests   = 0;
         results    = 0;
         sections   = 0;
         packets    = 0;
      endfunction

      function void add_word(logic [7:0] value, logic [7:0] run_len, logic done);
         ts_word_type w;
         w.value   = value;
         w.run_len = run_len;
         w.done    = done;
         due.push_back(w);
      endfunction

      function void crc_update(logic [7:0] b);
         logic top;
         for (int i = 7; i >= 0; i--) begin
            top = crc[CRC_W-1] ^ b[i];
            crc = crc << 1;
            if (top)
               crc ^= CRC_POLY;
         end
      endfunction

      // open a packet with its header when none is open, then place the byte
      function void place(logic [7:0] value);
         logic [7:0] pid_hi;
         if (pos == 0) begin
            pid_hi = {3'b000, pid[PID_W-1:8]};
            if (open_first)
               pid_hi |= START_FLAG;
            cc = cc + 4'd1;
            add_word(SYNC_BYTE, 8'd1, 1'b0);
            add_word(pid_hi, 8'd1, 1'b0);
            add_word(pid[7:0], 8'd1, 1'b0);
            add_word(CC_BASE | {4'h0, cc}, 8'd1, 1'b0);
            pos = HEADER_BYTES;
            if (open_first) begin
               add_word(POINTER_BYTE, 8'd1, 1'b0);
               pos++;
            end
            open_first = 1'b0;
            packets++;
         end
         add_word(value, 8'd1, 1'b0);
         pos++;
         if (pos >= PACKET_BYTES)
            pos = 0;
      endfunction

      function void note_request(logic [7:0] b, logic is_last);
         logic [CRC_W-1:0] sum;
         requests++;
         crc_update(b);
         place(b);
         if (is_last) begin
            sum = crc;
            place(sum[31:24]);
            place(sum[23:16]);
            place(sum[15:8]);
            place(sum[7:0]);
            if (pos != 0)
               add_word(PAD_BYTE, 8'(PACKET_BYTES - pos), 1'b1);
            else
               due[due.size()-1].done = 1'b1;
            pos        = 0;
            open_first = 1'b1;
            crc        = CRC_INIT;
            sections++;
         end
      endfunction

      function void check_result(logic [7:0] value, logic [7:0] run_len, logic done);
         ts_word_type want;
         results++;
         if (due.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("unexpected result %0d: byte %h run %0d done %b",
                        results, value, run_len, done);
            return;
         end
         want = due.pop_front();
         if (want.value !== value || want.run_len !== run_len || want.done !== done) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display({"result %0d: expected byte %h run %0d done %b, ",
                         "got byte %h run %0d done %b"},
                        results, want.value, want.run_len, want.done,
                        value, run_len, done);
         end
      endfunction
   endclass

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_push         = 1'b0;
   logic             req_full;
   logic [7:0]       req_section_byte = '0;
   logic             req_final_byte   = 1'b0;
   logic             rsp_empty;
   logic             rsp_pop          = 1'b0;
   logic [7:0]       rsp_out_byte;
   logic [7:0]       rsp_run_length;
   logic             rsp_section_done;
   logic             csr_wr_en        = 1'b0;
   logic [PID_W-1:0] csr_wr_data      = '0;

   logic [15:0]      pop_pattern      = 16'hFFFF;
   logic [3:0]       pop_slot         = '0;
   int unsigned      burst_left       = 0;
   int unsigned      max_gap          = 0;
   int unsigned      sent_in_phase    = 0;
   int unsigned      quiet            = 0;
   section_scoreboard sb = new();

   psi_section_packetizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_section_byte (req_section_byte),
      .req_final_byte   (req_final_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_length   (rsp_run_length),
      .rsp_section_done (rsp_section_done),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_pop  <= pop_pattern[pop_slot];
      pop_slot <= pop_slot + 4'd1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            sb.check_result(rsp_out_byte, rsp_run_length, rsp_section_done);
         if (req_push && !req_full)
            sb.note_request(req_section_byte, req_final_byte);
         if ((rsp_pop && !rsp_empty) || (req_push && !req_full))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout: nothing taken for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, sb.due.size());
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // hold the request until taken; gaps between bursts when max_gap is set
   task automatic push_request(input logic [7:0] b, input logic is_last);
      if (burst_left == 0) begin
         if (max_gap != 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_push         <= 1'b1;
      req_section_byte <= b;
      req_final_byte   <= is_last;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
      sent_in_phase++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (sb.due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_pid(input logic [PID_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.pid = value;
   endtask

   // pause_at drains and changes the stream id before that byte of the section
   task automatic send_section(input int unsigned len, input int unsigned pause_at);
      for (int unsigned i = 1; i <= len; i++) begin
         if (i == pause_at) begin
            drain_results();
            write_pid(PID_W'($urandom()));
         end
         push_request(8'($urandom()), i == len);
      end
   endtask

   task automatic run_phase(input logic [PID_W-1:0] pid, input int unsigned goal,
                            input int unsigned long_len, input int unsigned pause_at,
                            input int unsigned gap, input logic [15:0] pattern);
      drain_results();
      write_pid(pid);
      max_gap       = gap;
      pop_pattern   = pattern;
      sent_in_phase = 0;
      if (long_len != 0)
         send_section(long_len, pause_at);
      while (sent_in_phase < goal)
         send_section($urandom_range(1, 12), 0);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      write_pid({PID_W{1'b1}});
      push_request(8'h00, 1'b1);
      push_request(8'hFF, 1'b1);
      push_request(8'hFF, 1'b0);
      push_request(8'h00, 1'b0);
      push_request(8'h5A, 1'b0);
      push_request(8'hA5, 1'b1);
      drain_results();
      write_pid('0);
      push_request(8'h80, 1'b0);
      push_request(8'h01, 1'b1);
      push_request(8'h7F, 1'b0);
      push_request(8'hFE, 1'b0);
      push_request(8'h00, 1'b1);
      push_request(8'h47, 1'b1);

      run_phase(PID_W'($urandom()), 20, 0, 0, 6, 16'($urandom()) | 16'h0001);
      // 179 body bytes plus the CRC fill the first packet exactly
      run_phase({PID_W{1'b1}}, 185, 179, 0, 0, 16'hFFFF);
      // CRC split by the second header, id changed mid-section
      run_phase('0, 195, $urandom_range(180, 182), 150, 4,
                16'($urandom()) | 16'h8001);
      run_phase(PID_W'($urandom()), 16, 0, 0, 10, 16'h0101);
      drain_results();

      $display(
         "covered %0d requests in %0d sections, %0d packets, %0d results, %0d mismatches",
         sb.requests, sb.sections, sb.packets, sb.results, sb.errors);
      $display(
         "ids at both extremes and random, exact packet fit, CRC split, mid-section id change");
      if (sb.errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
